// File: hdl/spq_pkg.sv
// Shared types, codes and default sizes of the stable priority queue.
package spq_pkg;

    localparam int SPQ_CAPACITY      = 16;
    localparam int SPQ_TAG_BITS      = 32;
    localparam int SPQ_PRIORITY_BITS = 8;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LIST   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INS,
        S_RMV,
        S_LIST
    } t_state;

endpackage

// File: hdl/stable_priority_queue_top.sv
// Top level of the stable priority queue: control sequencer around one entry RAM.
//
// The queue holds up to CAPACITY entries in one RAM, kept sorted with the highest
// priority first and equal priorities in arrival order; the RAM is used as a ring
// whose head moves on remove. A request is taken when start is high and busy is
// low, and every result is shown for one cycle with o_valid, so the receiver must
// take it when it comes. A remove keeps busy high while it takes the head entry,
// a list while it reads out every stored entry, and an insert while it scans from
// the tail, moving each lower entry back one place per cycle (the RAM has one
// write port) and then writing the new entry. Rejected inserts, removes and lists
// on an empty queue, and inserts into an empty queue, leave busy low. Each result
// is registered and appears in the cycle after the cycle that produces it.
module stable_priority_queue_top #(
    parameter int CAPACITY      = spq_pkg::SPQ_CAPACITY,
    parameter int TAG_BITS      = spq_pkg::SPQ_TAG_BITS,
    parameter int PRIORITY_BITS = spq_pkg::SPQ_PRIORITY_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_operation,
    input  logic [TAG_BITS-1:0]      i_job_tag,
    input  logic [PRIORITY_BITS-1:0] i_job_priority,
    output logic                     o_valid,
    output logic [1:0]               o_status,
    output logic [TAG_BITS-1:0]      o_out_tag,
    output logic [PRIORITY_BITS-1:0] o_out_priority,
    output logic                     o_last
);

    import spq_pkg::*;

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = TAG_BITS + PRIORITY_BITS;

    t_state r_state, n_state;

    logic [PW-1:0]            r_head, n_head;
    logic [CW-1:0]            r_count, n_count;
    logic [PW-1:0]            r_idx, n_idx;
    logic [TAG_BITS-1:0]      r_tag, n_tag;
    logic [PRIORITY_BITS-1:0] r_pri, n_pri;

    logic                     r_valid, n_valid;
    logic [1:0]               r_status, n_status;
    logic [TAG_BITS-1:0]      r_otag, n_otag;
    logic [PRIORITY_BITS-1:0] r_opri, n_opri;
    logic                     r_last, n_last;

    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [PW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic                     accept;
    logic                     full;
    logic                     empty;
    logic [PW-1:0]            cnt_m1;
    logic [PRIORITY_BITS-1:0] rd_pri;
    logic [TAG_BITS-1:0]      rd_tag;
    logic                     stays_ahead;
    logic                     list_last;

    function automatic logic [PW-1:0] phys(input logic [PW-1:0] head,
                                           input logic [PW-1:0] offset);
        logic [PW:0] sum;
        sum = {1'b0, head} + {1'b0, offset};
        if (sum >= (PW+1)'(CAPACITY)) begin
            sum = sum - (PW+1)'(CAPACITY);
        end
        return sum[PW-1:0];
    endfunction

    spq_ram #(
        .WIDTH(EW),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign accept      = start && (r_state == S_IDLE);
    assign full        = (r_count == CW'(CAPACITY));
    assign empty       = (r_count == '0);
    assign cnt_m1      = PW'(r_count - 1'b1);
    assign rd_pri      = ram_rdata[EW-1:TAG_BITS];
    assign rd_tag      = ram_rdata[TAG_BITS-1:0];
    assign stays_ahead = (rd_pri >= r_pri);
    assign list_last   = (r_idx == cnt_m1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_operation)
                        OP_INSERT: if (!full && !empty) begin
                            n_state = S_SCAN;
                        end
                        OP_REMOVE: if (!empty) begin
                            n_state = S_RMV;
                        end
                        OP_LIST: if (!empty) begin
                            n_state = S_LIST;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (stays_ahead) begin
                    n_state = S_IDLE;
                end else if (r_idx == '0) begin
                    n_state = S_INS;
                end
            end
            S_INS: n_state = S_IDLE;
            S_RMV: n_state = S_IDLE;
            S_LIST: if (list_last) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        n_tag     = r_tag;
        n_pri     = r_pri;
        n_valid   = 1'b0;
        n_status  = ST_OK;
        n_otag    = '0;
        n_opri    = '0;
        n_last    = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = phys(r_head, PW'(r_idx + 1'b1));
        ram_wdata = {r_pri, r_tag};
        ram_raddr = r_head;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_tag = i_job_tag;
                    n_pri = i_job_priority;
                    unique case (i_operation)
                        OP_INSERT: begin
                            if (full) begin
                                n_valid  = 1'b1;
                                n_status = ST_FULL;
                            end else if (empty) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_head;
                                ram_wdata = {i_job_priority, i_job_tag};
                                n_count   = r_count + 1'b1;
                                n_valid   = 1'b1;
                            end else begin
                                ram_raddr = phys(r_head, cnt_m1);
                                n_idx     = cnt_m1;
                            end
                        end
                        OP_REMOVE, OP_LIST: begin
                            n_idx = '0;
                            if (empty) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end
                        end
                        default: n_valid = 1'b0;
                    endcase
                end
            end
            S_SCAN: begin
                ram_we = 1'b1;
                if (stays_ahead) begin
                    n_count = r_count + 1'b1;
                    n_valid = 1'b1;
                end else begin
                    ram_wdata = ram_rdata;
                    if (r_idx != '0) begin
                        ram_raddr = phys(r_head, PW'(r_idx - 1'b1));
                        n_idx     = PW'(r_idx - 1'b1);
                    end
                end
            end
            S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = r_head;
                n_count   = r_count + 1'b1;
                n_valid   = 1'b1;
            end
            S_RMV: begin
                n_head  = phys(r_head, PW'(1));
                n_count = r_count - 1'b1;
                n_valid = 1'b1;
                n_otag  = rd_tag;
                n_opri  = rd_pri;
            end
            S_LIST: begin
                n_valid   = 1'b1;
                n_otag    = rd_tag;
                n_opri    = rd_pri;
                n_last    = list_last;
                ram_raddr = phys(r_head, PW'(r_idx + 1'b1));
                n_idx     = PW'(r_idx + 1'b1);
            end
            default: n_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_tag    <= n_tag;
        r_pri    <= n_pri;
        r_status <= n_status;
        r_otag   <= n_otag;
        r_opri   <= n_opri;
        r_last   <= n_last;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_out_tag      = r_otag;
    assign o_out_priority = r_opri;
    assign o_last         = r_last;

    // The entry count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // A remove always produces its single, final result right after the read.
    a_remove_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RMV |=> o_valid && o_last && o_status == ST_OK)
        else $error("remove did not produce its result");

    // An insert into a full queue is rejected at once and leaves the count alone.
    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_operation == OP_INSERT && full
        |=> o_valid && o_status == ST_FULL && $stable(r_count))
        else $error("insert into full queue not rejected");

    // The insertion scan only visits stored entries.
    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> ({1'b0, r_idx} < (PW+1)'(r_count)))
        else $error("scan index outside the stored entries");

    // A list ends on the last stored entry and then releases busy.
    a_list_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LIST && list_last |=> o_valid && o_last && !busy)
        else $error("list did not end on the last entry");

endmodule

// File: hdl/spq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
